>>> hw/rtl/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// Shared types, codes and decimal helpers of the clock setting menu.
// ----------------------------------------------------------------------------
`default_nettype none

package csm_pkg;

  localparam int TIMER_BITS = 20;
  localparam int CFG_W      = 20;
  localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [CFG_W-1:0]      OFF_TIMEOUT_RESET = CFG_W'(30000);
  localparam logic [TIMER_BITS-1:0] TIMER_MAX         = {TIMER_BITS{1'b1}};

  // word index of a register (paddr[2])
  localparam logic REG_OFF_TIMEOUT = 1'b0;

  typedef enum logic [3:0] {
    CMD_TICK        = 4'd0,
    CMD_SET         = 4'd1,
    CMD_INC         = 4'd2,
    CMD_DEC         = 4'd3,
    CMD_SET_LONG    = 4'd4,
    CMD_INC_LONG    = 4'd5,
    CMD_DEC_LONG    = 4'd6,
    CMD_FORCE_SETUP = 4'd7,
    CMD_SYNC_START  = 4'd8,
    CMD_SYNC_STEP   = 4'd9,
    CMD_SYNC_END    = 4'd10,
    CMD_ERROR       = 4'd11
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_CLOCK  = 3'd0,
    MODE_TIME   = 3'd1,
    MODE_SILENT = 3'd2,
    MODE_CAL    = 3'd3,
    MODE_SYNC   = 3'd4,
    MODE_ERROR  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    COMMIT_NONE   = 2'd0,
    COMMIT_TIME   = 2'd1,
    COMMIT_SILENT = 2'd2,
    COMMIT_CAL    = 2'd3
  } commit_e;

  typedef logic [3:0]      digit_t;
  typedef digit_t [3:0]    quad_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic [4:0] rtc_hours;
    logic [5:0] rtc_minutes;
    logic [4:0] silent_start;
    logic [4:0] silent_end;
    logic       cal_plus;
    logic [8:0] cal_value;
    logic       in_silent;
    logic [3:0] msg_index;
  } item_t;

  typedef struct packed {
    mode_e      mode;
    digit_t     digit_a;
    digit_t     digit_b;
    digit_t     digit_c;
    digit_t     digit_d;
    logic [1:0] cursor;
    logic       display_on;
    commit_e    commit_kind;
    logic [4:0] commit_first;
    logic [8:0] commit_second;
    logic [3:0] message;
  } result_t;

  // {tens, units} of a value below 100
  function automatic logic [7:0] dec2(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] rem;
    tens = '0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 7'(10 * k)) tens = 4'(k);
    end
    rem = v - 7'(tens) * 7'd10;
    return {tens, rem[3:0]};
  endfunction

  function automatic quad_t load_pair(input logic [4:0] hi, input logic [5:0] lo);
    quad_t      q;
    logic [7:0] h;
    logic [7:0] l;
    h = dec2(7'(hi));
    l = dec2(7'(lo));
    q[0] = h[7:4];
    q[1] = h[3:0];
    q[2] = l[7:4];
    q[3] = l[3:0];
    return q;
  endfunction

  function automatic quad_t load_cal(input logic plus, input logic [8:0] v);
    quad_t      q;
    logic [3:0] hund;
    logic [8:0] rem;
    logic [7:0] tu;
    hund = '0;
    for (int k = 1; k <= 5; k++) begin
      if (v >= 9'(100 * k)) hund = 4'(k);
    end
    rem  = v - 9'(hund) * 9'd100;
    tu   = dec2(rem[6:0]);
    q[0] = {3'b000, plus};
    q[1] = hund;
    q[2] = tu[7:4];
    q[3] = tu[3:0];
    return q;
  endfunction

  function automatic logic [7:0] pair_value(input digit_t t, input digit_t u);
    return 8'(t) * 8'd10 + 8'(u);
  endfunction

  function automatic logic [10:0] cal_magnitude(input digit_t h, input digit_t t,
                                                input digit_t u);
    return 11'(h) * 11'd100 + 11'(t) * 11'd10 + 11'(u);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/csm_if.sv
// ----------------------------------------------------------------------------
// csm_item_if / csm_result_if
// Valid/ready channels for menu events and menu results.
// ----------------------------------------------------------------------------
`default_nettype none

interface csm_item_if;
  logic       valid;
  logic       ready;
  logic [3:0] cmd;
  logic [4:0] rtc_hours;
  logic [5:0] rtc_minutes;
  logic [4:0] silent_start;
  logic [4:0] silent_end;
  logic       cal_plus;
  logic [8:0] cal_value;
  logic       in_silent;
  logic [3:0] msg_index;

  modport source (
    output valid, cmd, rtc_hours, rtc_minutes, silent_start, silent_end,
           cal_plus, cal_value, in_silent, msg_index,
    input  ready
  );
  modport sink (
    input  valid, cmd, rtc_hours, rtc_minutes, silent_start, silent_end,
           cal_plus, cal_value, in_silent, msg_index,
    output ready
  );
endinterface

interface csm_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [3:0] digit_a;
  logic [3:0] digit_b;
  logic [3:0] digit_c;
  logic [3:0] digit_d;
  logic [1:0] cursor;
  logic       display_on;
  logic [1:0] commit_kind;
  logic [4:0] commit_first;
  logic [8:0] commit_second;
  logic [3:0] message;

  modport source (
    output valid, mode, digit_a, digit_b, digit_c, digit_d, cursor, display_on,
           commit_kind, commit_first, commit_second, message,
    input  ready
  );
  modport sink (
    input  valid, mode, digit_a, digit_b, digit_c, digit_d, cursor, display_on,
           commit_kind, commit_first, commit_second, message,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/csm_cfg.sv
// ----------------------------------------------------------------------------
// csm_cfg
// APB register file holding the display-off timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module csm_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [csm_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [csm_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [csm_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  output logic      [csm_pkg::CFG_W-1:0]      off_timeout
);
  import csm_pkg::*;

  logic wr_hit;

  // byte lanes within a word are ignored
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_OFF_TIMEOUT);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      off_timeout <= OFF_TIMEOUT_RESET;
    end else if (wr_hit) begin
      off_timeout <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_OFF_TIMEOUT) begin
      prdata = APB_DATA_W'(off_timeout);
    end else begin
      prdata = '0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/csm_core.sv
// ----------------------------------------------------------------------------
// csm_core
// Menu state and the single-pass update that one event applies to it.
// ----------------------------------------------------------------------------
`default_nettype none

module csm_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       fire,
  input  wire csm_pkg::item_t             item,
  input  wire logic [csm_pkg::CFG_W-1:0]  off_timeout,
  output csm_pkg::result_t                result
);
  import csm_pkg::*;

  mode_e                 mode, mode_next;
  quad_t                 d, d_next;
  logic [1:0]            cursor, cursor_next;
  logic                  wizard, wizard_next;
  logic                  screen, screen_next;
  logic [TIMER_BITS-1:0] idle, idle_next;

  commit_e    kind;
  logic [4:0] first;
  logic [8:0] second;
  logic [3:0] msg;

  quad_t       time_load, silent_load, cal_load, rtc_load;
  logic [1:0]  tix, uix;
  logic        minutes;
  digit_t      tens_max, units_max;
  digit_t      n1, n2;
  logic [7:0]  pv_first, pv_second;
  logic [10:0] cal_mag;
  logic [3:0]  msg_sat;
  cmd_e        cmd;

  assign cmd         = cmd_e'(item.cmd);
  assign time_load   = load_pair(item.rtc_hours, item.rtc_minutes);
  assign rtc_load    = time_load;
  assign silent_load = load_pair(item.silent_start, {1'b0, item.silent_end});
  assign cal_load    = load_cal(item.cal_plus, item.cal_value);
  assign pv_first    = pair_value(d[0], d[1]);
  assign pv_second   = pair_value(d[2], d[3]);
  assign cal_mag     = cal_magnitude(d[1], d[2], d[3]);
  assign msg_sat     = (item.msg_index > 4'd8) ? 4'd8 : item.msg_index;

  // digit pair under the cursor: hours pair or minutes/end pair
  assign tix     = {cursor[1], 1'b0};
  assign uix     = {cursor[1], 1'b1};
  assign minutes = cursor[1] && (mode == MODE_TIME);

  always_comb begin
    if (minutes) begin
      units_max = 4'd9;
    end else if (d[tix] < 4'd2) begin
      units_max = 4'd9;
    end else if (d[tix] == 4'd2) begin
      units_max = 4'd3;
    end else begin
      units_max = 4'd0;
    end
    tens_max = minutes ? 4'd5 : 4'd2;
  end

  always_comb begin : next_state
    mode_next   = mode;
    d_next      = d;
    cursor_next = cursor;
    wizard_next = wizard;
    screen_next = screen;
    idle_next   = idle;
    kind        = COMMIT_NONE;
    first       = '0;
    second      = '0;
    msg         = '0;
    n1          = d[1] + 4'd1;
    n2          = d[2] + 4'd1;
    case (cmd)
      CMD_TICK: begin
        if (idle != TIMER_MAX) idle_next = idle + TIMER_BITS'(1);
        if (mode == MODE_CLOCK) d_next = rtc_load;
        if (mode != MODE_SYNC && CMP_W'(idle_next) > CMP_W'(off_timeout)) begin
          screen_next = 1'b0;
          if (mode != MODE_ERROR) mode_next = MODE_CLOCK;
        end
      end
      CMD_SET, CMD_INC, CMD_DEC, CMD_SET_LONG, CMD_INC_LONG, CMD_DEC_LONG: begin
        screen_next = 1'b1;
        idle_next   = '0;
        // a press on a dark screen only wakes it
        if (screen) begin
          case (mode)
            MODE_CLOCK: begin
              if (cmd == CMD_SET_LONG && !item.in_silent) begin
                mode_next   = MODE_TIME;
                wizard_next = 1'b0;
                cursor_next = '0;
                d_next      = time_load;
              end else if (cmd == CMD_INC_LONG) begin
                mode_next   = MODE_SILENT;
                cursor_next = '0;
                d_next      = silent_load;
              end else if (cmd == CMD_DEC_LONG) begin
                mode_next   = MODE_CAL;
                cursor_next = '0;
                d_next      = cal_load;
              end
            end
            MODE_TIME, MODE_SILENT, MODE_CAL: begin
              case (cmd)
                CMD_SET: begin
                  if (cursor != 2'd3) begin
                    cursor_next = cursor + 2'd1;
                  end else begin
                    cursor_next = '0;
                    if (mode == MODE_CAL) begin
                      kind   = COMMIT_CAL;
                      first  = 5'(d[0]);
                      second = (cal_mag > 11'd511) ? 9'd511 : cal_mag[8:0];
                      if (wizard) begin
                        mode_next   = MODE_TIME;
                        wizard_next = 1'b0;
                        d_next      = time_load;
                      end else begin
                        mode_next = MODE_CLOCK;
                      end
                    end else begin
                      kind   = (mode == MODE_TIME) ? COMMIT_TIME : COMMIT_SILENT;
                      first  = (pv_first > 8'd31) ? 5'd31 : pv_first[4:0];
                      second = 9'(pv_second);
                      if (mode == MODE_TIME) begin
                        mode_next = MODE_SYNC;
                      end else if (wizard) begin
                        // wizard chain: silent hours, then calibration
                        mode_next = MODE_CAL;
                        d_next    = cal_load;
                      end else begin
                        mode_next = MODE_CLOCK;
                      end
                    end
                  end
                end
                CMD_INC: begin
                  if (mode == MODE_CAL) begin
                    case (cursor)
                      2'd0: d_next[0] = (d[0] != 4'd0) ? 4'd0 : 4'd1;
                      2'd1: begin
                        if (d[1] < 4'd5) begin
                          d_next[1] = n1;
                          if (n1 == 4'd5) begin
                            if (d[2] > 4'd1) d_next[2] = 4'd1;
                            if ((d[2] >= 4'd1) && (d[3] > 4'd1)) d_next[3] = 4'd1;
                          end
                        end
                      end
                      2'd2: begin
                        if (d[2] < ((d[1] == 4'd5) ? 4'd1 : 4'd9)) begin
                          d_next[2] = n2;
                          if (d[1] == 4'd5 && n2 == 4'd1 && d[3] > 4'd1) d_next[3] = 4'd1;
                        end
                      end
                      default: begin
                        if (d[3] < ((d[1] == 4'd5 && d[2] == 4'd1) ? 4'd1 : 4'd9)) begin
                          d_next[3] = d[3] + 4'd1;
                        end
                      end
                    endcase
                  end else if (!cursor[0]) begin
                    if (d[tix] < tens_max) begin
                      d_next[tix] = d[tix] + 4'd1;
                      // clamp units when hours reach the twenties
                      if (!minutes && d[tix] == 4'd1 && d[uix] > 4'd3) d_next[uix] = 4'd3;
                    end
                  end else begin
                    if (d[uix] < units_max) d_next[uix] = d[uix] + 4'd1;
                  end
                end
                CMD_DEC: begin
                  if (mode == MODE_CAL && cursor == 2'd0) begin
                    d_next[0] = (d[0] != 4'd0) ? 4'd0 : 4'd1;
                  end else if (d[cursor] != 4'd0) begin
                    d_next[cursor] = d[cursor] - 4'd1;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      CMD_FORCE_SETUP: begin
        wizard_next = 1'b1;
        mode_next   = MODE_SILENT;
        cursor_next = '0;
        d_next      = silent_load;
        screen_next = 1'b1;
        idle_next   = '0;
      end
      CMD_SYNC_START, CMD_SYNC_STEP, CMD_SYNC_END, CMD_ERROR: begin
        msg         = msg_sat + 4'd1;
        screen_next = 1'b1;
        idle_next   = '0;
        if (cmd == CMD_ERROR) begin
          mode_next = MODE_ERROR;
        end else if (cmd == CMD_SYNC_END) begin
          mode_next = MODE_CLOCK;
        end else begin
          mode_next = MODE_SYNC;
        end
      end
      default: ;
    endcase
  end

  always_comb begin : outputs
    result.mode          = mode_next;
    result.digit_a       = d_next[0];
    result.digit_b       = d_next[1];
    result.digit_c       = d_next[2];
    result.digit_d       = d_next[3];
    result.cursor        = cursor_next;
    result.display_on    = screen_next;
    result.commit_kind   = kind;
    result.commit_first  = first;
    result.commit_second = second;
    result.message       = msg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_SYNC;
      d      <= '0;
      cursor <= '0;
      wizard <= 1'b0;
      screen <= 1'b0;
      idle   <= '0;
    end else if (fire) begin
      mode   <= mode_next;
      d      <= d_next;
      cursor <= cursor_next;
      wizard <= wizard_next;
      screen <= screen_next;
      idle   <= idle_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/clock_setting_menu_fsm.sv
// ----------------------------------------------------------------------------
// clock_setting_menu_fsm
// Menu, edit and display-power controller of a small clock display.
// ----------------------------------------------------------------------------
// One event enters per cycle and each produces exactly one result transaction:
// the event is captured in an input register, the menu state is updated in a
// single combinational pass, and the result lands in an output register. The
// menu state register feeds back into the next event's update in the following
// cycle, which sets the one-per-cycle rate. A stalled result holds the pipeline;
// up to two events are in flight. The display-off timeout is set through the APB
// port at address 0 and resets to 30000 ticks.
`default_nettype none

module clock_setting_menu_fsm (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [csm_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [csm_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [csm_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  csm_item_if.sink                            req,
  csm_result_if.source                        rsp
);
  import csm_pkg::*;

  logic [CFG_W-1:0] off_timeout;
  item_t            item_q;
  logic             item_valid;
  result_t          res_d;
  result_t          res_q;
  logic             res_valid;
  logic             res_free;
  logic             fire;

  csm_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .off_timeout (off_timeout)
  );

  csm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (item_q),
    .off_timeout (off_timeout),
    .result      (res_d)
  );

  assign res_free  = !res_valid || rsp.ready;
  assign fire      = item_valid && res_free;
  assign req.ready = !item_valid || res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      item_q.cmd          <= req.cmd;
      item_q.rtc_hours    <= req.rtc_hours;
      item_q.rtc_minutes  <= req.rtc_minutes;
      item_q.silent_start <= req.silent_start;
      item_q.silent_end   <= req.silent_end;
      item_q.cal_plus     <= req.cal_plus;
      item_q.cal_value    <= req.cal_value;
      item_q.in_silent    <= req.in_silent;
      item_q.msg_index    <= req.msg_index;
    end
  end

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign rsp.valid         = res_valid;
  assign rsp.mode          = res_q.mode;
  assign rsp.digit_a       = res_q.digit_a;
  assign rsp.digit_b       = res_q.digit_b;
  assign rsp.digit_c       = res_q.digit_c;
  assign rsp.digit_d       = res_q.digit_d;
  assign rsp.cursor        = res_q.cursor;
  assign rsp.display_on    = res_q.display_on;
  assign rsp.commit_kind   = res_q.commit_kind;
  assign rsp.commit_first  = res_q.commit_first;
  assign rsp.commit_second = res_q.commit_second;
  assign rsp.message       = res_q.message;

endmodule

`default_nettype wire

>>> hw/rtl/csm_chk.sv
// ----------------------------------------------------------------------------
// csm_chk
// Port-level checks on result transactions of the clock setting menu.
// ----------------------------------------------------------------------------
`default_nettype none

module csm_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [2:0] rsp_mode,
  input wire logic [1:0] rsp_cursor,
  input wire logic       rsp_display_on,
  input wire logic [1:0] rsp_commit_kind,
  input wire logic [4:0] rsp_commit_first,
  input wire logic [8:0] rsp_commit_second,
  input wire logic [3:0] rsp_message
);
  import csm_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode) &&
      $stable(rsp_commit_kind) && $stable(rsp_message) && $stable(rsp_cursor))
    else $error("result changed while stalled");

  a_no_commit_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_commit_kind == COMMIT_NONE |->
      rsp_commit_first == 5'd0 && rsp_commit_second == 9'd0)
    else $error("commit values without a commit");

  // messages come only from sync and error events, which wake the display
  a_message: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_message != 4'd0 |->
      rsp_commit_kind == COMMIT_NONE && rsp_display_on &&
      (rsp_mode == MODE_CLOCK || rsp_mode == MODE_SYNC || rsp_mode == MODE_ERROR))
    else $error("message with inconsistent mode or display");

  a_time_commit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_commit_kind == COMMIT_TIME |->
      rsp_mode == MODE_SYNC && rsp_cursor == 2'd0 && rsp_display_on)
    else $error("time commit did not enter sync");

endmodule

bind clock_setting_menu_fsm csm_chk u_csm_chk (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_mode          (rsp.mode),
  .rsp_cursor        (rsp.cursor),
  .rsp_display_on    (rsp.display_on),
  .rsp_commit_kind   (rsp.commit_kind),
  .rsp_commit_first  (rsp.commit_first),
  .rsp_commit_second (rsp.commit_second),
  .rsp_message       (rsp.message)
);

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clock setting menu controller. Events go in
// over a valid/ready channel and every result transaction is compared field
// by field against an in-bench model of the menu, edit and display-power
// logic. The off-timeout register is set over APB between phases.
// ----------------------------------------------------------------------------

module tb;
  import csm_pkg::*;

  localparam int             QUIET_LIMIT     = 2000;
  localparam int             RSP_HOLD_CYCLES = 300;
  localparam int             MAX_REPORTS     = 10;
  localparam logic [3:0]     CMD_UNDEFINED   = 4'd13;
  localparam logic [APB_ADDR_W-1:0] TIMEOUT_ADDR = {REG_OFF_TIMEOUT, 2'b00};

  logic clk = 1'b0;
  logic rst;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  csm_item_if   req_if ();
  csm_result_if rsp_if ();

  clock_setting_menu_fsm u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_if),
    .rsp     (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Menu model state
  // --------------------------------------------------------------------------
  mode_e                 pm_mode;
  int unsigned           pm_digit [4];
  logic [2:0]            pm_cursor;
  bit                    pm_wizard;
  bit                    pm_screen;
  logic [TIMER_BITS-1:0] pm_idle;
  logic [CFG_W-1:0]      pm_off_limit;

  result_t pending_results [$];

  bit gaps_on = 1'b1;
  int stalls_asked = 0;
  int stalls_served = 0;
  int quiet_cycles = 0;
  int n_mismatch = 0;
  int n_events = 0;
  int n_results = 0;
  int n_settings = 1;
  int n_blanks = 0;
  int n_commits [4] = '{0, 0, 0, 0};

  function automatic void wake_screen();
    pm_screen = 1'b1;
    pm_idle   = '0;
  endfunction

  function automatic void load_two_pairs(input int unsigned hi, input int unsigned lo);
    pm_digit[0] = hi / 10;
    pm_digit[1] = hi % 10;
    pm_digit[2] = lo / 10;
    pm_digit[3] = lo % 10;
  endfunction

  function automatic void enter_time(input item_t it);
    pm_mode   = MODE_TIME;
    pm_wizard = 1'b0;
    pm_cursor = '0;
    load_two_pairs(it.rtc_hours, it.rtc_minutes);
  endfunction

  function automatic void enter_silent(input item_t it);
    pm_mode   = MODE_SILENT;
    pm_cursor = '0;
    load_two_pairs(it.silent_start, it.silent_end);
  endfunction

  function automatic void enter_cal(input item_t it);
    int unsigned v;
    v           = it.cal_value;
    pm_mode     = MODE_CAL;
    pm_cursor   = '0;
    pm_digit[0] = it.cal_plus;
    pm_digit[1] = v / 100;
    pm_digit[2] = (v / 10) % 10;
    pm_digit[3] = v % 10;
  endfunction

  // tens at t, units at t+1; hours cap at 23, minutes at 59
  function automatic void bump_pair(input int t, input bit minutes);
    int unsigned lim;
    if (pm_cursor == t) begin
      lim = minutes ? 5 : 2;
      if (pm_digit[t] < lim) begin
        pm_digit[t]++;
        if (!minutes && pm_digit[t] == 2 && pm_digit[t+1] > 3) pm_digit[t+1] = 3;
      end
    end else begin
      if (minutes || pm_digit[t] < 2) lim = 9;
      else if (pm_digit[t] == 2) lim = 3;
      else lim = 0;
      if (pm_digit[t+1] < lim) pm_digit[t+1]++;
    end
  endfunction

  // sign, then a magnitude that clamps at 511
  function automatic void bump_cal();
    int unsigned lim;
    case (pm_cursor)
      3'd0: pm_digit[0] = (pm_digit[0] != 0) ? 0 : 1;
      3'd1: begin
        if (pm_digit[1] < 5) begin
          pm_digit[1]++;
          if (pm_digit[1] == 5) begin
            if (pm_digit[2] > 1) pm_digit[2] = 1;
            if (pm_digit[2] == 1 && pm_digit[3] > 1) pm_digit[3] = 1;
          end
        end
      end
      3'd2: begin
        lim = (pm_digit[1] == 5) ? 1 : 9;
        if (pm_digit[2] < lim) begin
          pm_digit[2]++;
          if (pm_digit[1] == 5 && pm_digit[2] == 1 && pm_digit[3] > 1) pm_digit[3] = 1;
        end
      end
      default: begin
        lim = (pm_digit[1] == 5 && pm_digit[2] == 1) ? 1 : 9;
        if (pm_digit[3] < lim) pm_digit[3]++;
      end
    endcase
  endfunction

  function automatic result_t next_menu_result(input item_t it);
    result_t     r;
    commit_e     kind;
    int unsigned first;
    int unsigned second;
    int unsigned msg;
    int          c;
    bit          was_dark;
    bit          commit;
    kind   = COMMIT_NONE;
    first  = 0;
    second = 0;
    msg    = 0;
    commit = 1'b0;
    if (it.cmd == CMD_TICK) begin
      if (pm_idle != TIMER_MAX) pm_idle++;
      if (pm_mode == MODE_CLOCK) load_two_pairs(it.rtc_hours, it.rtc_minutes);
      if (pm_mode != MODE_SYNC && pm_idle > pm_off_limit) begin
        if (pm_screen) n_blanks++;
        pm_screen = 1'b0;
        if (pm_mode != MODE_ERROR) pm_mode = MODE_CLOCK;
      end
    end else if (it.cmd <= CMD_DEC_LONG) begin
      was_dark = !pm_screen;
      wake_screen();
      if (!was_dark) begin
        if (pm_mode == MODE_CLOCK) begin
          if (it.cmd == CMD_SET_LONG && !it.in_silent) enter_time(it);
          else if (it.cmd == CMD_INC_LONG) enter_silent(it);
          else if (it.cmd == CMD_DEC_LONG) enter_cal(it);
        end else if (pm_mode == MODE_TIME || pm_mode == MODE_SILENT ||
                     pm_mode == MODE_CAL) begin
          case (it.cmd)
            CMD_SET: begin
              if (pm_cursor >= 3) commit = 1'b1;
              else pm_cursor++;
            end
            CMD_INC: begin
              if (pm_mode == MODE_CAL) bump_cal();
              else if (pm_cursor < 2) bump_pair(0, 1'b0);
              else bump_pair(2, pm_mode == MODE_TIME);
            end
            CMD_DEC: begin
              c = pm_cursor[1:0];
              if (pm_mode == MODE_CAL && c == 0) pm_digit[0] = (pm_digit[0] != 0) ? 0 : 1;
              else if (pm_digit[c] > 0) pm_digit[c]--;
            end
            default: ;
          endcase
          if (commit) begin
            pm_cursor = '0;
            if (pm_mode == MODE_CAL) begin
              kind   = COMMIT_CAL;
              first  = pm_digit[0];
              second = pm_digit[1] * 100 + pm_digit[2] * 10 + pm_digit[3];
              if (pm_wizard) enter_time(it);
              else pm_mode = MODE_CLOCK;
            end else begin
              kind   = (pm_mode == MODE_TIME) ? COMMIT_TIME : COMMIT_SILENT;
              first  = pm_digit[0] * 10 + pm_digit[1];
              second = pm_digit[2] * 10 + pm_digit[3];
              if (pm_mode == MODE_TIME) pm_mode = MODE_SYNC;
              else if (pm_wizard) enter_cal(it);
              else pm_mode = MODE_CLOCK;
            end
            if (first > 31) first = 31;
            if (second > 511) second = 511;
          end
        end
      end
    end else if (it.cmd == CMD_FORCE_SETUP) begin
      pm_wizard = 1'b1;
      enter_silent(it);
      wake_screen();
    end else if (it.cmd <= CMD_ERROR) begin
      msg = ((it.msg_index > 4'd8) ? 8 : int'(it.msg_index)) + 1;
      wake_screen();
      if (it.cmd == CMD_ERROR) pm_mode = MODE_ERROR;
      else if (it.cmd == CMD_SYNC_END) pm_mode = MODE_CLOCK;
      else pm_mode = MODE_SYNC;
    end
    r.mode          = pm_mode;
    r.digit_a       = 4'(pm_digit[0]);
    r.digit_b       = 4'(pm_digit[1]);
    r.digit_c       = 4'(pm_digit[2]);
    r.digit_d       = 4'(pm_digit[3]);
    r.cursor        = pm_cursor[1:0];
    r.display_on    = pm_screen;
    r.commit_kind   = kind;
    r.commit_first  = 5'(first);
    r.commit_second = 9'(second);
    r.message       = 4'(msg);
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf({"mode=%0d digits=%0d,%0d,%0d,%0d cursor=%0d disp=%0d ",
                      "commit=%0d/%0d/%0d msg=%0d"},
                     r.mode, r.digit_a, r.digit_b, r.digit_c, r.digit_d, r.cursor,
                     r.display_on, r.commit_kind, r.commit_first, r.commit_second, r.message);
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got.mode          = mode_e'(rsp_if.mode);
      got.digit_a       = rsp_if.digit_a;
      got.digit_b       = rsp_if.digit_b;
      got.digit_c       = rsp_if.digit_c;
      got.digit_d       = rsp_if.digit_d;
      got.cursor        = rsp_if.cursor;
      got.display_on    = rsp_if.display_on;
      got.commit_kind   = commit_e'(rsp_if.commit_kind);
      got.commit_first  = rsp_if.commit_first;
      got.commit_second = rsp_if.commit_second;
      got.message       = rsp_if.message;
      n_results++;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("ERROR: result %0d with no event pending: %s", n_results, show(got));
      end else begin
        want = pending_results.pop_front();
        if (got.mode !== want.mode || got.digit_a !== want.digit_a ||
            got.digit_b !== want.digit_b || got.digit_c !== want.digit_c ||
            got.digit_d !== want.digit_d || got.cursor !== want.cursor ||
            got.display_on !== want.display_on || got.commit_kind !== want.commit_kind ||
            got.commit_first !== want.commit_first ||
            got.commit_second !== want.commit_second || got.message !== want.message) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS) begin
            $display("ERROR: result %0d mismatch", n_results);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result sink: random backpressure, or a long hold when a test asks for one
  initial begin : result_sink
    int held;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stalls_asked != stalls_served) begin
        rsp_if.ready <= 1'b0;
        for (held = 1; held < RSP_HOLD_CYCLES; held++) @(posedge clk);
        stalls_served++;
      end else begin
        rsp_if.ready <= !gaps_on || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_event(input item_t it);
    result_t want;
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 27) begin
        req_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= it.cmd;
    req_if.rtc_hours    <= it.rtc_hours;
    req_if.rtc_minutes  <= it.rtc_minutes;
    req_if.silent_start <= it.silent_start;
    req_if.silent_end   <= it.silent_end;
    req_if.cal_plus     <= it.cal_plus;
    req_if.cal_value    <= it.cal_value;
    req_if.in_silent    <= it.in_silent;
    req_if.msg_index    <= it.msg_index;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    want = next_menu_result(it);
    pending_results.push_back(want);
    n_commits[want.commit_kind]++;
    n_events++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_off_timeout();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= TIMEOUT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DATA_W'(pm_off_limit)) begin
      n_mismatch++;
      if (n_mismatch <= MAX_REPORTS)
        $display("ERROR: off_timeout read %0d, expected %0d", prdata, pm_off_limit);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_off_timeout(input logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TIMEOUT_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pm_off_limit = value[CFG_W-1:0];
    n_settings++;
    read_off_timeout();
  endtask

  function automatic item_t plain_event(input cmd_e c);
    item_t it;
    it.cmd          = c;
    it.rtc_hours    = 5'd12;
    it.rtc_minutes  = 6'd34;
    it.silent_start = 5'd22;
    it.silent_end   = 5'd6;
    it.cal_plus     = 1'b1;
    it.cal_value    = 9'd123;
    it.in_silent    = 1'b0;
    it.msg_index    = 4'd0;
    return it;
  endfunction

  // Mostly commands that make sense in the current mode, some noise
  function automatic item_t random_event();
    item_t it;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 7) begin
      it.cmd = 4'($urandom_range(0, 15));
    end else if (!pm_screen) begin
      it.cmd = (r < 25) ? CMD_TICK : 4'($urandom_range(CMD_SET, CMD_DEC_LONG));
    end else begin
      case (pm_mode)
        MODE_SYNC, MODE_ERROR: begin
          if (r < 45) it.cmd = CMD_SYNC_END;
          else if (r < 60) it.cmd = CMD_FORCE_SETUP;
          else if (r < 75) it.cmd = 4'($urandom_range(CMD_SYNC_START, CMD_ERROR));
          else if (r < 88) it.cmd = CMD_TICK;
          else it.cmd = 4'($urandom_range(CMD_SET, CMD_DEC_LONG));
        end
        MODE_CLOCK: begin
          if (r < 40) it.cmd = CMD_TICK;
          else if (r < 85) it.cmd = 4'($urandom_range(CMD_SET_LONG, CMD_DEC_LONG));
          else it.cmd = 4'($urandom_range(CMD_SET, CMD_ERROR));
        end
        default: begin
          if (r < 35) it.cmd = CMD_SET;
          else if (r < 60) it.cmd = CMD_INC;
          else if (r < 80) it.cmd = CMD_DEC;
          else if (r < 90) it.cmd = CMD_TICK;
          else it.cmd = 4'($urandom_range(CMD_SET_LONG, CMD_ERROR));
        end
      endcase
    end
    // occasionally push values past their nominal range
    it.rtc_hours    = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
    it.rtc_minutes  = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
    it.silent_start = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
    it.silent_end   = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
    it.cal_plus     = 1'($urandom);
    it.cal_value    = 9'($urandom_range(0, 511));
    it.in_silent    = ($urandom_range(0, 4) == 0);
    it.msg_index    = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
    return it;
  endfunction

  task automatic run_random(input int count);
    item_t it;
    int    done;
    done = 0;
    while (done < count) begin
      it = random_event();
      send_event(it);
      if (it.cmd <= CMD_ERROR) done++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    item_t it;
    read_off_timeout();
    send_event(plain_event(CMD_TICK));           // tick in sync with display off
    send_event(plain_event(CMD_INC));            // wake only
    it = plain_event(CMD_SYNC_START);
    it.msg_index = 4'd15;                        // saturates to the last message
    send_event(it);
    send_event(plain_event(CMD_SYNC_STEP));
    it = plain_event(CMD_SYNC_END);
    it.msg_index = 4'd8;
    send_event(it);
    it = plain_event(CMD_TICK);
    it.rtc_hours   = 5'd23;
    it.rtc_minutes = 6'd59;
    send_event(it);
    send_event(plain_event(CMD_SET));            // short press in clock does nothing
    it = plain_event(CMD_SET_LONG);
    it.in_silent = 1'b1;                         // blocked during silent hours
    send_event(it);
    it = plain_event(CMD_TICK);
    it.cmd = CMD_UNDEFINED;
    send_event(it);
    it = plain_event(CMD_SET_LONG);
    it.rtc_hours   = 5'd31;
    it.rtc_minutes = 6'd63;
    send_event(it);                              // time edit from out-of-range clock
    send_event(plain_event(CMD_DEC));
    send_event(plain_event(CMD_SET));
    send_event(plain_event(CMD_INC));
    send_event(plain_event(CMD_INC_LONG));       // long press in edit does nothing
    send_event(plain_event(CMD_SET));
    send_event(plain_event(CMD_SET));
    send_event(plain_event(CMD_INC));
    send_event(plain_event(CMD_SET));            // time commit, then sync
    it = plain_event(CMD_ERROR);
    it.msg_index = 4'd3;
    send_event(it);
    send_event(plain_event(CMD_DEC_LONG));       // ignored in error
    it = plain_event(CMD_FORCE_SETUP);
    it.silent_start = 5'd31;
    it.silent_end   = 5'd23;
    it.cal_plus     = 1'b0;
    it.cal_value    = 9'd499;
    repeat (4) begin
      send_event(it);                            // wizard entry, then three SETs
      it.cmd = CMD_SET;
    end
    send_event(it);                              // silent commit chains to calibration
    send_event(plain_event(CMD_DEC));            // flip sign
    send_event(plain_event(CMD_SET));
    send_event(plain_event(CMD_INC));            // hundreds to 5 clamps lower digits
    settle();
  endtask

  task automatic test_reset_timeout();
    run_random(100);
    settle();
  endtask

  task automatic test_short_timeouts();
    repeat (2) begin
      write_off_timeout(APB_DATA_W'($urandom_range(2, 40)));
      run_random(175);
      settle();
    end
  endtask

  task automatic test_minimum_timeout();
    write_off_timeout(APB_DATA_W'(1));
    run_random(150);
    settle();
  endtask

  task automatic test_back_to_back();
    write_off_timeout(APB_DATA_W'($urandom_range(5, 25)));
    gaps_on = 1'b0;
    run_random(150);
    settle();
    gaps_on = 1'b1;
  endtask

  task automatic test_result_stall();
    // hold the result side while events keep coming; the input must back up
    stalls_asked++;
    run_random(60);
    settle();
  endtask

  task automatic test_maximum_timeout();
    // upper bits are not part of the register
    write_off_timeout({12'hABC, {CFG_W{1'b1}}});
    run_random(150);
    settle();
  endtask

  initial begin
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    req_if.valid        = 1'b0;
    req_if.cmd          = CMD_TICK;
    req_if.rtc_hours    = '0;
    req_if.rtc_minutes  = '0;
    req_if.silent_start = '0;
    req_if.silent_end   = '0;
    req_if.cal_plus     = 1'b0;
    req_if.cal_value    = '0;
    req_if.in_silent    = 1'b0;
    req_if.msg_index    = '0;
    pm_mode      = MODE_SYNC;
    pm_digit     = '{0, 0, 0, 0};
    pm_cursor    = '0;
    pm_wizard    = 1'b0;
    pm_screen    = 1'b0;
    pm_idle      = '0;
    pm_off_limit = OFF_TIMEOUT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_reset_timeout();
    test_short_timeouts();
    test_minimum_timeout();
    test_back_to_back();
    test_result_stall();
    test_maximum_timeout();
    repeat (8) @(posedge clk);

    $display("Covered %0d menu events and %0d results over %0d off-timeout settings, %0d %s",
             n_events, n_results, n_settings, n_blanks, "blankings.");
    $display("Commits: time %0d, silent hours %0d, calibration %0d; one %0d-cycle stall.",
             n_commits[COMMIT_TIME], n_commits[COMMIT_SILENT], n_commits[COMMIT_CAL],
             RSP_HOLD_CYCLES);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_mismatch, pending_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
